[rtl/core/wrs_pkg.sv]
`timescale 1ns / 1ps

package wrs_pkg;

  // Hold buffer depth for trailing punctuation and element position width
  localparam int PUNCT_HOLD = 8;
  localparam int POS_WIDTH  = 32;
  localparam int HoldIdxW   = $clog2(PUNCT_HOLD);
  localparam int HoldCntW   = $clog2(PUNCT_HOLD + 1);

  // Request and result codes
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_END   = 1'b1;
  localparam logic ITEM_TEXT = 1'b0;
  localparam logic ITEM_SUM  = 1'b1;

  typedef enum logic [1:0] {
    CLS_END,
    CLS_WS,
    CLS_PUNCT,
    CLS_CHAR
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_OVF,
    ST_DRAIN,
    ST_CHAR,
    ST_SUM
  } ctrl_state_t;

  typedef struct packed {
    logic        req_type;
    logic        elem_is_residue;
    logic [20:0] elem_value;
    logic [31:0] src_offset;
    logic [2:0]  src_len;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  text_byte;
    logic [31:0] char_offset;
    logic        char_is_cap;
    logic [31:0] run_start_pos;
    logic [31:0] run_char_len;
    logic [31:0] run_byte_start;
    logic [31:0] run_byte_len;
    logic        first_cap;
    logic        all_caps;
    logic        hold_overflow;
    logic        last;
  } res_item_t;

  // One held punctuation mark (always ASCII)
  typedef struct packed {
    logic [6:0]  value;
    logic [31:0] offset;
    logic [2:0]  len;
  } mark_t;

  typedef struct packed {
    logic latch;      // capture input beat, advance position
    logic set_chunk;  // run is open
    logic push;       // push latched mark into hold buffer
    logic pop_emit;   // emit oldest held mark as text, commit it
    logic char_emit;  // emit next byte of latched character
    logic sum_emit;   // emit run summary
    logic close;      // clear run state
    logic set_ovf;    // note hold overflow
    logic last;       // last flag for pop_emit beat
  } dp_cmd_t;

  typedef struct packed {
    cls_t                cls;
    logic                in_chunk;
    logic                have_core;
    logic                hold_full;
    logic                hold_one;
    logic                hold_empty;
    logic                byte_last;
    logic                out_free;
    logic [HoldCntW-1:0] hold_cnt;
  } dp_sts_t;

  function automatic logic is_ws(input logic [20:0] c);
    return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D ||
           c == 21'h0C || c == 21'h0B;
  endfunction

  function automatic logic is_punct(input logic [20:0] c);
    return (c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
           (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E);
  endfunction

  function automatic logic is_upper(input logic [20:0] c);
    return c >= 21'h41 && c <= 21'h5A;
  endfunction

  // UTF-8 length of a codepoint, minus one
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] v);
    if (v < 21'h80) begin
      return 2'd0;
    end else if (v < 21'h800) begin
      return 2'd1;
    end else if (v < 21'h10000) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  // Byte idx of the UTF-8 form; ASCII capitals are lowercased
  function automatic logic [7:0] utf8_byte(input logic [20:0] v, input logic [1:0] idx);
    logic [1:0] lm1;
    logic [7:0] b;
    lm1 = utf8_len_m1(v);
    b = 8'h00;
    case (lm1)
      2'd0: b = is_upper(v) ? (v[7:0] + 8'h20) : v[7:0];
      2'd1: b = (idx == 2'd0) ? (8'hC0 | {3'b0, v[10:6]}) : (8'h80 | {2'b0, v[5:0]});
      2'd2: begin
        case (idx)
          2'd0:    b = 8'hE0 | {4'b0, v[15:12]};
          2'd1:    b = 8'h80 | {2'b0, v[11:6]};
          default: b = 8'h80 | {2'b0, v[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = 8'hF0 | {5'b0, v[20:18]};
          2'd1:    b = 8'h80 | {2'b0, v[17:12]};
          2'd2:    b = 8'h80 | {2'b0, v[11:6]};
          default: b = 8'h80 | {2'b0, v[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

[rtl/core/wrs_in_if.sv]
`timescale 1ns / 1ps

interface wrs_in_if import wrs_pkg::*;;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        elem_is_residue;
  logic [20:0] elem_value;
  logic [31:0] src_offset;
  logic [2:0]  src_len;

  modport source (output valid, req_type, elem_is_residue, elem_value, src_offset, src_len,
                  input ready);
  modport sink (input valid, req_type, elem_is_residue, elem_value, src_offset, src_len,
                output ready);
endinterface

[rtl/core/wrs_out_if.sv]
`timescale 1ns / 1ps

interface wrs_out_if import wrs_pkg::*;;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  text_byte;
  logic [31:0] char_offset;
  logic        char_is_cap;
  logic [31:0] run_start_pos;
  logic [31:0] run_char_len;
  logic [31:0] run_byte_start;
  logic [31:0] run_byte_len;
  logic        first_cap;
  logic        all_caps;
  logic        hold_overflow;
  logic        last;

  modport source (output valid, item_kind, text_byte, char_offset, char_is_cap,
                  run_start_pos, run_char_len, run_byte_start, run_byte_len,
                  first_cap, all_caps, hold_overflow, last,
                  input ready);
  modport sink (input valid, item_kind, text_byte, char_offset, char_is_cap,
                run_start_pos, run_char_len, run_byte_start, run_byte_len,
                first_cap, all_caps, hold_overflow, last,
                output ready);
endinterface

[rtl/core/word_run_segmenter.sv]
`timescale 1ns / 1ps
// word_run_segmenter
// Splits a stream of character elements into whitespace-separated runs,
// strips ASCII punctuation at both run edges and emits lowercased UTF-8
// text beats followed by one summary beat per run that kept a character.
// Channels: in_ch (sink) takes one element or an end-of-data request per
// beat; out_ch (source) gives text and summary beats, last set on the final
// beat caused by an input beat. Both are valid/ready handshakes.
// Flow: one input beat at a time. An input beat is taken in ST_IDLE and
// classified in the next cycle, in ST_DECIDE; its result beats then load
// the output register one at a time, with no result beat for some elements
// and up to PUNCT_HOLD + 4 result beats when held marks drain.
// The single output register paces the result beats; when the receiver stalls the
// sequencer waits with the result held and in_ch.ready stays low until the
// current input beat's results are all in the register.
// Reset (rst_n low, synchronous) clears the element position, the open run
// and the hold buffer fill count; the output register comes up empty.

module word_run_segmenter import wrs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  wrs_in_if.sink     in_ch,
  wrs_out_if.source  out_ch
);

  in_item_t  in_item;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      out_valid;
  res_item_t out_item;
  logic      in_ready;

  assign in_item = '{req_type:        in_ch.req_type,
                     elem_is_residue: in_ch.elem_is_residue,
                     elem_value:      in_ch.elem_value,
                     src_offset:      in_ch.src_offset,
                     src_len:         in_ch.src_len};
  assign in_ch.ready = in_ready;

  wrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.item_kind      = out_item.item_kind;
  assign out_ch.text_byte      = out_item.text_byte;
  assign out_ch.char_offset    = out_item.char_offset;
  assign out_ch.char_is_cap    = out_item.char_is_cap;
  assign out_ch.run_start_pos  = out_item.run_start_pos;
  assign out_ch.run_char_len   = out_item.run_char_len;
  assign out_ch.run_byte_start = out_item.run_byte_start;
  assign out_ch.run_byte_len   = out_item.run_byte_len;
  assign out_ch.first_cap      = out_item.first_cap;
  assign out_ch.all_caps       = out_item.all_caps;
  assign out_ch.hold_overflow  = out_item.hold_overflow;
  assign out_ch.last           = out_item.last;

  // Hold buffer never fills past its depth
  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.hold_cnt <= HoldCntW'(PUNCT_HOLD))
    else $error("hold buffer count past depth");

  // A kept character implies an open run
  a_core_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.have_core |-> sts.in_chunk)
    else $error("kept character outside a run");

  // One input beat at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while previous beat in work");

  // Summary beat always closes an input beat's results
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.item_kind == ITEM_SUM) |-> out_ch.last)
    else $error("summary beat without last");

endmodule

[rtl/core/wrs_dp.sv]
`timescale 1ns / 1ps

module wrs_dp import wrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  logic      out_ready,
  output logic      out_valid,
  output res_item_t out_item
);

  in_item_t             item_r;
  logic [POS_WIDTH-1:0] pos_r;
  logic [POS_WIDTH-1:0] cur_pos_r;
  logic                 in_chunk_r;
  logic                 have_core_r;
  logic [POS_WIDTH-1:0] start_pos_r;
  logic [31:0]          first_off_r;
  logic [31:0]          last_end_r;
  logic [31:0]          core_cnt_r;
  logic [31:0]          cap_cnt_r;
  logic                 first_cap_r;
  logic                 ovf_r;
  mark_t                hold_mem_r [PUNCT_HOLD];
  logic [HoldIdxW-1:0]  head_r;
  logic [HoldCntW-1:0]  cnt_r;
  logic [1:0]           byte_idx_r;
  logic                 out_valid_r;
  res_item_t            out_item_r;

  cls_t                 cls;
  logic                 cur_cap;
  logic [1:0]           nbytes_m1;
  logic                 byte_last;
  mark_t                head_mark;
  logic [HoldCntW:0]    tail_sum;
  logic [HoldIdxW-1:0]  tail;
  logic [HoldIdxW-1:0]  head_nxt;
  logic                 commit_en;
  logic [POS_WIDTH-1:0] c_pos;
  logic [31:0]          c_off;
  logic [2:0]           c_len;
  logic                 c_cap;
  logic                 load;
  res_item_t            res_nxt;
  logic [POS_WIDTH+31:0] start_ext;

  // Classify latched element
  always_comb begin
    if (item_r.req_type == REQ_END) begin
      cls = CLS_END;
    end else if (!item_r.elem_is_residue && is_ws(item_r.elem_value)) begin
      cls = CLS_WS;
    end else if (!item_r.elem_is_residue && is_punct(item_r.elem_value)) begin
      cls = CLS_PUNCT;
    end else begin
      cls = CLS_CHAR;
    end
  end

  assign cur_cap   = !item_r.elem_is_residue && is_upper(item_r.elem_value);
  assign nbytes_m1 = item_r.elem_is_residue ? 2'd0 : utf8_len_m1(item_r.elem_value);
  assign byte_last = (byte_idx_r == nbytes_m1);

  // Hold buffer ring indexes
  assign head_mark = hold_mem_r[head_r];
  assign tail_sum  = (HoldCntW+1)'(head_r) + (HoldCntW+1)'(cnt_r);
  assign tail      = (tail_sum >= (HoldCntW+1)'(PUNCT_HOLD)) ?
                     HoldIdxW'(tail_sum - (HoldCntW+1)'(PUNCT_HOLD)) :
                     HoldIdxW'(tail_sum);
  assign head_nxt  = (head_r == HoldIdxW'(PUNCT_HOLD - 1)) ? '0 : head_r + 1'b1;

  // Character commit source: oldest held mark or latched element
  assign commit_en = cmd.pop_emit || (cmd.char_emit && byte_last);
  assign c_pos     = cur_pos_r;
  assign c_off     = cmd.pop_emit ? head_mark.offset : item_r.src_offset;
  assign c_len     = cmd.pop_emit ? head_mark.len : item_r.src_len;
  assign c_cap     = cmd.pop_emit ? 1'b0 : cur_cap;

  assign start_ext = {32'd0, start_pos_r};

  // Result beat build
  always_comb begin
    res_nxt = '0;
    if (cmd.sum_emit) begin
      res_nxt.item_kind      = ITEM_SUM;
      res_nxt.run_start_pos  = start_ext[31:0];
      res_nxt.run_char_len   = core_cnt_r;
      res_nxt.run_byte_start = first_off_r;
      res_nxt.run_byte_len   = last_end_r - first_off_r;
      res_nxt.first_cap      = first_cap_r;
      res_nxt.all_caps       = (core_cnt_r != 32'd0) && (cap_cnt_r == core_cnt_r);
      res_nxt.hold_overflow  = ovf_r;
      res_nxt.last           = 1'b1;
    end else begin
      res_nxt.item_kind   = ITEM_TEXT;
      res_nxt.char_offset = core_cnt_r;
      if (cmd.pop_emit) begin
        res_nxt.text_byte = {1'b0, head_mark.value};
        res_nxt.last      = cmd.last;
      end else begin
        res_nxt.text_byte = item_r.elem_is_residue ? item_r.elem_value[7:0] :
                            utf8_byte(item_r.elem_value, byte_idx_r);
        res_nxt.char_is_cap = cur_cap;
        res_nxt.last        = byte_last;
      end
    end
  end

  assign load = cmd.pop_emit || cmd.char_emit || cmd.sum_emit;

  // Control and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      in_chunk_r  <= 1'b0;
      have_core_r <= 1'b0;
      start_pos_r <= '0;
      first_off_r <= '0;
      last_end_r  <= '0;
      core_cnt_r  <= '0;
      cap_cnt_r   <= '0;
      first_cap_r <= 1'b0;
      ovf_r       <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
      byte_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch) begin
        pos_r <= (in_item.req_type == REQ_END) ? '0 : pos_r + 1'b1;
      end
      if (cmd.set_chunk) begin
        in_chunk_r <= 1'b1;
      end
      if (commit_en) begin
        if (!have_core_r) begin
          have_core_r <= 1'b1;
          start_pos_r <= c_pos;
          first_off_r <= c_off;
          first_cap_r <= c_cap;
        end
        last_end_r <= c_off + {29'd0, c_len};
        core_cnt_r <= core_cnt_r + 32'd1;
        if (c_cap) begin
          cap_cnt_r <= cap_cnt_r + 32'd1;
        end
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.pop_emit) begin
        head_r <= head_nxt;
      end
      if (cmd.push && !cmd.pop_emit) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.pop_emit && !cmd.push) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.char_emit) begin
        byte_idx_r <= byte_last ? 2'd0 : byte_idx_r + 2'd1;
      end
      if (cmd.close) begin
        in_chunk_r  <= 1'b0;
        have_core_r <= 1'b0;
        start_pos_r <= '0;
        first_off_r <= '0;
        last_end_r  <= '0;
        core_cnt_r  <= '0;
        cap_cnt_r   <= '0;
        first_cap_r <= 1'b0;
        ovf_r       <= 1'b0;
        cnt_r       <= '0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r    <= in_item;
      cur_pos_r <= pos_r;
    end
    if (cmd.push) begin
      hold_mem_r[tail] <= '{value:  item_r.elem_value[6:0],
                            offset: item_r.src_offset,
                            len:    item_r.src_len};
    end
    if (load) begin
      out_item_r <= res_nxt;
    end
  end

  always_comb begin
    sts.cls        = cls;
    sts.in_chunk   = in_chunk_r;
    sts.have_core  = have_core_r;
    sts.hold_full  = (cnt_r == HoldCntW'(PUNCT_HOLD));
    sts.hold_one   = (cnt_r == HoldCntW'(1));
    sts.hold_empty = (cnt_r == '0);
    sts.byte_last  = byte_last;
    sts.out_free   = !out_valid_r || out_ready;
    sts.hold_cnt   = cnt_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/core/wrs_ctrl.sv]
`timescale 1ns / 1ps

module wrs_ctrl import wrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (sts.cls)
          CLS_END: state_nxt = sts.have_core ? ST_SUM : ST_IDLE;
          CLS_WS:  state_nxt = (sts.in_chunk && sts.have_core) ? ST_SUM : ST_IDLE;
          CLS_PUNCT: state_nxt = (sts.have_core && sts.hold_full) ? ST_OVF : ST_IDLE;
          default: state_nxt = sts.hold_empty ? ST_CHAR : ST_DRAIN;
        endcase
      end
      ST_OVF: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_DRAIN: begin
        if (sts.out_free && sts.hold_one) state_nxt = ST_CHAR;
      end
      ST_CHAR: begin
        if (sts.out_free && sts.byte_last) state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DECIDE: begin
        unique case (sts.cls)
          CLS_END:   cmd.close = !sts.have_core;
          CLS_WS:    cmd.close = sts.in_chunk && !sts.have_core;
          CLS_PUNCT: begin
            cmd.set_chunk = 1'b1;
            cmd.push      = sts.have_core && !sts.hold_full;
          end
          default:   cmd.set_chunk = 1'b1;
        endcase
      end
      ST_OVF: begin
        if (sts.out_free) begin
          cmd.pop_emit = 1'b1;
          cmd.last     = 1'b1;
          cmd.push     = 1'b1;
          cmd.set_ovf  = 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd.pop_emit = sts.out_free;
      end
      ST_CHAR: begin
        cmd.char_emit = sts.out_free;
      end
      ST_SUM: begin
        if (sts.out_free) begin
          cmd.sum_emit = 1'b1;
          cmd.close    = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
